// File: rtl/ilp_pkg.sv
// Shared types and character constants for the integer literal parser.
`default_nettype none

package ilp_pkg;

  // One input item: a character or the terminator.
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_end;
  } ilp_in_t;

  // One result item, given for each terminator.
  typedef struct packed {
    logic signed [63:0] value;
    logic               convert_ok;
    logic               is_number;
  } ilp_out_t;

  typedef enum logic [1:0] {
    PH_LEAD_WS = 2'd0,
    PH_SIGN_WS = 2'd1,
    PH_ZERO    = 2'd2,
    PH_DIGITS  = 2'd3
  } ilp_phase_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } ilp_radix_e;

  // Parser state as seen from outside the core.
  typedef struct packed {
    ilp_phase_e phase;
    logic       negative_sign;
    logic       plus_sign;
    logic       rejected;
  } ilp_status_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_O_LO  = 8'h6F;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  // Value of 'a' as a digit.
  localparam logic [3:0] DIGIT_ALPHA_OFS = 4'd10;

endpackage

`default_nettype wire

// File: rtl/ilp_in_stage.sv
// Input register stage of the integer literal parser.
`default_nettype none

module ilp_in_stage
  import ilp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  ilp_in_t in_data_i,
  input  logic    take_i,
  output logic    s1_valid_o,
  output ilp_in_t s1_data_o
);

  logic    valid_q, valid_d;
  ilp_in_t data_q;
  logic    accept;

  // Stall only while a held item cannot move on this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/ilp_parse_core.sv
// Parse state, digit accumulation and result formation.
`default_nettype none

module ilp_parse_core
  import ilp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  ilp_in_t     data_i,
  input  logic        slot_free_i,
  output logic        take_o,
  output logic        res_valid_o,
  output ilp_out_t    res_o,
  output ilp_status_t status_o
);

  ilp_phase_e  phase_q, phase_d;
  ilp_radix_e  radix_q, radix_d;
  ilp_radix_e  radix_eff;
  logic        neg_q, neg_d;
  logic        plus_q, plus_d;
  logic        rej_q, rej_d;
  logic [63:0] acc_q, acc_d;

  logic [7:0]  c;
  logic        is_ws, dig_num, dig_alpha, dig_below, dig_ok;
  logic [3:0]  dig_val;
  logic [63:0] dig_ext, mac;
  logic        step, fin;

  assign c      = data_i.char_code;
  assign take_o = valid_i && (!data_i.is_end || slot_free_i);
  assign fin    = take_o && data_i.is_end;
  assign step   = take_o && !data_i.is_end && !rej_q;

  assign is_ws     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign dig_num   = (c >= CH_0) && (c <= CH_9);
  assign dig_alpha = (c >= CH_A_LO) && (c <= CH_F_LO);
  assign dig_val   = dig_num ? 4'(c - CH_0) : (4'(c - CH_A_LO) + DIGIT_ALPHA_OFS);
  assign dig_ext   = {60'd0, dig_val};

  // Outside the digit phase a digit always counts as decimal.
  assign radix_eff = (phase_q == PH_DIGITS) ? radix_q : RADIX_DEC;

  always_comb begin
    unique case (radix_eff)
      RADIX_DEC: dig_below = (dig_val < 4'd10);
      RADIX_BIN: dig_below = (dig_val < 4'd2);
      RADIX_OCT: dig_below = (dig_val < 4'd8);
      RADIX_HEX: dig_below = 1'b1;
      default:   dig_below = 1'b0;
    endcase
  end

  assign dig_ok = (dig_num || dig_alpha) && dig_below;

  always_comb begin
    unique case (radix_eff)
      RADIX_DEC: mac = (acc_q << 3) + (acc_q << 1) + dig_ext;
      RADIX_BIN: mac = {acc_q[62:0], 1'b0} | dig_ext;
      RADIX_OCT: mac = {acc_q[60:0], 3'd0} | dig_ext;
      RADIX_HEX: mac = {acc_q[59:0], 4'd0} | dig_ext;
      default:   mac = acc_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    plus_d  = plus_q;
    rej_d   = rej_q;
    acc_d   = acc_q;
    if (fin) begin
      phase_d = PH_LEAD_WS;
      radix_d = RADIX_DEC;
      neg_d   = 1'b0;
      plus_d  = 1'b0;
      rej_d   = 1'b0;
      acc_d   = 64'd0;
    end else if (step) begin
      unique case (phase_q)
        PH_LEAD_WS, PH_SIGN_WS: begin
          priority if (is_ws) begin
            phase_d = phase_q;
          end else if (phase_q == PH_LEAD_WS && c == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGN_WS;
          end else if (phase_q == PH_LEAD_WS && c == CH_PLUS) begin
            plus_d  = 1'b1;
            phase_d = PH_SIGN_WS;
          end else if (c == CH_0) begin
            acc_d   = 64'd0;
            phase_d = PH_ZERO;
          end else if (dig_ok) begin
            radix_d = RADIX_DEC;
            acc_d   = mac;
            phase_d = PH_DIGITS;
          end else begin
            rej_d = 1'b1;
          end
        end
        PH_ZERO: begin
          priority if (c == CH_B_LO) begin
            radix_d = RADIX_BIN;
            phase_d = PH_DIGITS;
          end else if (c == CH_O_LO) begin
            radix_d = RADIX_OCT;
            phase_d = PH_DIGITS;
          end else if (c == CH_X_LO) begin
            radix_d = RADIX_HEX;
            phase_d = PH_DIGITS;
          end else if (dig_ok) begin
            radix_d = RADIX_DEC;
            acc_d   = mac;
            phase_d = PH_DIGITS;
          end else begin
            rej_d = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (dig_ok) begin
            acc_d = mac;
          end else begin
            rej_d = 1'b1;
          end
        end
        default: rej_d = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD_WS;
      radix_q <= RADIX_DEC;
      neg_q   <= 1'b0;
      plus_q  <= 1'b0;
      rej_q   <= 1'b0;
      acc_q   <= 64'd0;
    end else begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      plus_q  <= plus_d;
      rej_q   <= rej_d;
      acc_q   <= acc_d;
    end
  end

  always_comb begin
    res_o.is_number  = !rej_q;
    res_o.convert_ok = !rej_q && !plus_q;
    if (res_o.convert_ok) begin
      res_o.value = neg_q ? (64'd0 - acc_q) : acc_q;
    end else begin
      res_o.value = 64'd0;
    end
  end

  assign res_valid_o = fin;

  assign status_o.phase         = phase_q;
  assign status_o.negative_sign = neg_q;
  assign status_o.plus_sign     = plus_q;
  assign status_o.rejected      = rej_q;

endmodule

`default_nettype wire

// File: rtl/ilp_out_stage.sv
// Result register stage of the integer literal parser.
`default_nettype none

module ilp_out_stage
  import ilp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  ilp_out_t data_i,
  output logic     slot_free_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ilp_out_t out_data_o
);

  logic     valid_q, valid_d;
  ilp_out_t data_q;

  // The slot frees up when empty or when its item leaves this cycle.
  assign slot_free_o = !valid_q || !out_stall_i;
  assign valid_d     = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/integer_literal_parser_unit.sv
// Top level of the integer literal parser: input stage, parse core, result stage.
`default_nettype none

// Integer literal parser. Feed one character per item; an item with is_end set
// closes the literal and yields one result item (value, convert_ok, is_number),
// after which the parser is back in its reset state. Leading whitespace and one
// optional sign (followed by optional whitespace) are allowed, then an optional
// 0b / 0o / 0x prefix, then lower-case digits below the base. A '-' negates the
// value modulo 2^64; a '+' keeps is_number but clears convert_ok; any syntax
// error clears both and forces value to 0. The block takes one item per clock
// cycle unless a terminator waits for the result slot: the parse core performs
// one 64-bit shift-and-add per character, and that adder path sets the cycle.
// An accepted item is held in the input register until the core takes it; a
// terminator's result is in the result register from the edge after the core
// takes it. Character items keep flowing while a result waits on out_stall_i.
module integer_literal_parser_unit
  import ilp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ilp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ilp_out_t out_data_o
);

  logic        s1_valid;
  ilp_in_t     s1_data;
  logic        take;
  logic        slot_free;
  logic        res_valid;
  ilp_out_t    res;
  ilp_status_t status;

  // Hold the accepted item until the core takes it.
  ilp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_data_o  (s1_data)
  );

  // Advance the parse state; on a terminator, form the result and reset.
  ilp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .data_i      (s1_data),
    .slot_free_i (slot_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  // Hold the result until the receiver drops stall.
  ilp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .data_i      (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A terminator returns the parser to its idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (status.phase == PH_LEAD_WS) && !status.rejected &&
                  !status.negative_sign && !status.plus_sign)
    else $error("parser state not cleared after terminator");

  // A failed conversion never carries a value, and conversion implies a number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.convert_ok || (out_data_o.value == 64'sd0)) &&
                    (!out_data_o.convert_ok || out_data_o.is_number))
    else $error("inconsistent result flags");

  // The core never loads the result register while it still holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !res_valid)
    else $error("result overwritten while stalled");

  // Input stalls only while a terminator is held in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid && s1_data.is_end)
    else $error("input stalled without a waiting terminator");

endmodule

`default_nettype wire

// File: tb/integer_literal_parser_unit_tb.sv
// Self-checking testbench for the integer literal parser: scoreboard class and top module.

// Scoreboard: tracks the parser state for every accepted item, queues the result
// each terminator should yield, and checks delivered results in order.
class literal_scoreboard;
  ilp_pkg::ilp_phase_e phase;
  ilp_pkg::ilp_radix_e radix;
  bit                  minus_seen;
  bit                  plus_seen;
  bit                  bad_syntax;
  logic [63:0]         acc;
  ilp_pkg::ilp_out_t   expected_q[$];
  int                  error_count;

  function new();
    error_count = 0;
    clear_literal();
  endfunction

  // Return to the state the parser holds between literals.
  function void clear_literal();
    phase      = ilp_pkg::PH_LEAD_WS;
    radix      = ilp_pkg::RADIX_DEC;
    minus_seen = 1'b0;
    plus_seen  = 1'b0;
    bad_syntax = 1'b0;
    acc        = '0;
  endfunction

  function int unsigned base_of(ilp_pkg::ilp_radix_e r);
    case (r)
      ilp_pkg::RADIX_BIN: return 2;
      ilp_pkg::RADIX_OCT: return 8;
      ilp_pkg::RADIX_HEX: return 16;
      default:            return 10;
    endcase
  endfunction

  // Value of a digit character, or 16 for anything that is no digit at all.
  function int unsigned digit_of(logic [7:0] c);
    if (c >= ilp_pkg::CH_0 && c <= ilp_pkg::CH_9) return c - ilp_pkg::CH_0;
    if (c >= ilp_pkg::CH_A_LO && c <= ilp_pkg::CH_F_LO)
      return c - ilp_pkg::CH_A_LO + ilp_pkg::DIGIT_ALPHA_OFS;
    return 16;
  endfunction

  function void take_digit(logic [7:0] c);
    int unsigned d;
    int unsigned b;
    d = digit_of(c);
    b = base_of(radix);
    if (d >= b) begin
      bad_syntax = 1'b1;
    end else begin
      acc   = acc * 64'(b) + 64'(d);
      phase = ilp_pkg::PH_DIGITS;
    end
  endfunction

  function void note_input(ilp_pkg::ilp_in_t item);
    ilp_pkg::ilp_out_t res;
    logic [7:0]        c;
    bit                is_space;
    c = item.char_code;
    if (item.is_end) begin
      res.is_number  = !bad_syntax;
      res.convert_ok = !bad_syntax && !plus_seen;
      res.value      = '0;
      if (res.convert_ok) res.value = minus_seen ? 64'd0 - acc : acc;
      expected_q.push_back(res);
      clear_literal();
      return;
    end
    if (bad_syntax) return;
    is_space = (c == ilp_pkg::CH_SPACE) || (c >= ilp_pkg::CH_TAB && c <= ilp_pkg::CH_CR);
    case (phase)
      ilp_pkg::PH_LEAD_WS, ilp_pkg::PH_SIGN_WS: begin
        if (is_space) begin
        end else if (phase == ilp_pkg::PH_LEAD_WS && c == ilp_pkg::CH_MINUS) begin
          minus_seen = 1'b1;
          phase      = ilp_pkg::PH_SIGN_WS;
        end else if (phase == ilp_pkg::PH_LEAD_WS && c == ilp_pkg::CH_PLUS) begin
          plus_seen = 1'b1;
          phase     = ilp_pkg::PH_SIGN_WS;
        end else if (c == ilp_pkg::CH_0) begin
          acc   = '0;
          phase = ilp_pkg::PH_ZERO;
        end else begin
          radix = ilp_pkg::RADIX_DEC;
          take_digit(c);
        end
      end
      ilp_pkg::PH_ZERO: begin
        if (c == ilp_pkg::CH_B_LO) begin
          radix = ilp_pkg::RADIX_BIN;
          phase = ilp_pkg::PH_DIGITS;
        end else if (c == ilp_pkg::CH_O_LO) begin
          radix = ilp_pkg::RADIX_OCT;
          phase = ilp_pkg::PH_DIGITS;
        end else if (c == ilp_pkg::CH_X_LO) begin
          radix = ilp_pkg::RADIX_HEX;
          phase = ilp_pkg::PH_DIGITS;
        end else begin
          radix = ilp_pkg::RADIX_DEC;
          take_digit(c);
        end
      end
      ilp_pkg::PH_DIGITS: take_digit(c);
      default: bad_syntax = 1'b1;
    endcase
  endfunction

  // Print one line per mismatch and count it.
  task report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  task check_result(ilp_pkg::ilp_out_t got);
    ilp_pkg::ilp_out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: value=%h ok=%b num=%b",
                                got.value, got.convert_ok, got.is_number));
      return;
    end
    want = expected_q.pop_front();
    if (got.value !== want.value)
      report_mismatch($sformatf("value %h, expected %h", got.value, want.value));
    if (got.convert_ok !== want.convert_ok)
      report_mismatch($sformatf("convert_ok %b, expected %b", got.convert_ok, want.convert_ok));
    if (got.is_number !== want.is_number)
      report_mismatch($sformatf("is_number %b, expected %b", got.is_number, want.is_number));
  endtask

  function int pending();
    return expected_q.size();
  endfunction
endclass

module integer_literal_parser_unit_tb;
  import ilp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] text_t[$];

  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEMS_TOTAL    = 1950;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  ilp_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  ilp_out_t out_data_o;

  literal_scoreboard sb;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       items_sent;
  int unsigned       quiet_cycles;

  integer_literal_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver side: stall at random with the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check every result the receiver takes. Outputs read here still hold their
  // values from before the edge, since the block updates them by nonblocking
  // assignment.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, holding it until the block takes it; idle first at random.
  task automatic push_item(input ilp_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(item);
    items_sent++;
  endtask

  // Send the characters of one literal, then a terminator with a random
  // (ignored) character code.
  task automatic send_text(input text_t txt);
    ilp_in_t item;
    foreach (txt[i]) begin
      item.char_code = txt[i];
      item.is_end    = 1'b0;
      push_item(item);
    end
    item.char_code = 8'($urandom_range(255));
    item.is_end    = 1'b1;
    push_item(item);
  endtask

  task automatic send_str(input string s);
    text_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_text(txt);
  endtask

  // One of the six whitespace characters: tab through carriage return, or space.
  function automatic logic [7:0] ws_char();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d);
    return (d < DIGIT_ALPHA_OFS) ? CH_0 + 8'(d) : CH_A_LO + 8'(d) - 8'(DIGIT_ALPHA_OFS);
  endfunction

  // Random literals until the item count reaches stop_at. Most are well formed
  // (whitespace, sign, prefix, digits below the base), some run long enough to
  // wrap the accumulator, a fifth get one random byte dropped in, and a few are
  // pure noise.
  task automatic run_random(input int unsigned stop_at);
    text_t             txt;
    int unsigned       sel;
    int unsigned       r;
    int unsigned       n_digits;
    int unsigned       base;
    ilp_radix_e        rdx;
    logic [7:0]        junk;
    while (items_sent < stop_at) begin
      txt = {};
      sel = $urandom_range(99);
      if (sel < 6) begin
        repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(2) == 0) repeat ($urandom_range(1, 3)) txt.push_back(ws_char());
        r = $urandom_range(5);
        if (r < 2) txt.push_back(CH_MINUS);
        else if (r == 2) txt.push_back(CH_PLUS);
        if (r <= 2 && $urandom_range(3) == 0) txt.push_back(ws_char());
        rdx = ilp_radix_e'($urandom_range(3));
        case (rdx)
          RADIX_BIN: begin
            txt.push_back(CH_0);
            txt.push_back(CH_B_LO);
            base = 2;
            n_digits = $urandom_range(60, 70);
          end
          RADIX_OCT: begin
            txt.push_back(CH_0);
            txt.push_back(CH_O_LO);
            base = 8;
            n_digits = $urandom_range(20, 24);
          end
          RADIX_HEX: begin
            txt.push_back(CH_0);
            txt.push_back(CH_X_LO);
            base = 16;
            n_digits = $urandom_range(15, 18);
          end
          default: begin
            if ($urandom_range(4) == 0) txt.push_back(CH_0);
            base = 10;
            n_digits = $urandom_range(19, 22);
          end
        endcase
        // Long runs (around and past 64 bits) only now and then.
        if ($urandom_range(7) != 0) n_digits = $urandom_range(12);
        repeat (n_digits) txt.push_back(digit_char($urandom_range(base - 1)));
        if (sel >= 80) begin
          junk = 8'($urandom_range(255));
          r    = $urandom_range(2);
          if (txt.size() == 0 || r == 0) txt.push_back(junk);
          else if (r == 1) txt[$urandom_range(txt.size() - 1)] = junk;
          else txt.insert($urandom_range(txt.size()), junk);
          // Characters after a possible rejection must be ignored.
          if ($urandom_range(1) == 0) txt.push_back(digit_char($urandom_range(15)));
        end
      end
      send_text(txt);
    end
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    quiet_cycles   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed literals, no idling: empty text, lone minus, plus with a bare
    // hex prefix, digit too large for octal, second sign, whitespace after
    // digits, upper-case letter, a byte of all ones, and a small negative
    // binary value after leading whitespace.
    send_str("");
    send_str("-");
    send_str("+0x");
    send_str("0o9");
    send_str("--");
    send_str("7 ");
    send_str("F");
    send_str("\377");
    send_str("\t-0b1");

    // Random literals over four idling phases.
    run_random(ITEMS_TOTAL / 4);
    send_idle_pct = 51;
    run_random(ITEMS_TOTAL / 2);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    run_random(3 * ITEMS_TOTAL / 4);
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    run_random(ITEMS_TOTAL);

    // Drain: wait for every queued result, then a few cycles for strays.
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ilp_pkg.sv
rtl/ilp_in_stage.sv
rtl/ilp_parse_core.sv
rtl/ilp_out_stage.sv
rtl/integer_literal_parser_unit.sv
tb/integer_literal_parser_unit_tb.sv
